@@ rtl/pfa_pkg.sv @@
// ---------------------------------------------------------------------------
// pfa_pkg: shared types and constants for the paged frame allocator
// Command and status codes, field widths and parameter defaults.
// ---------------------------------------------------------------------------
package pfa_pkg;

    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 4;
    localparam int SIZE_W     = 19;
    localparam int ADDR_W     = 18;
    localparam int PS_W       = 13;
    localparam int STATUS_W   = 2;
    localparam int NRES_W     = 7;

    localparam int DEF_NUM_FRAMES = 64;
    localparam int DEF_NUM_PROCS  = 16;

    localparam logic [PS_W-1:0]   PAGE_SIZE_RESET = 13'd64;
    localparam logic [PS_W-1:0]   PAGE_SIZE_MAX   = 13'd4096;
    localparam logic [NRES_W-1:0] MAX_RESULTS     = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESIZE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_BAD    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_ERR   = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

endpackage

@@ rtl/paged_frame_allocator_and_splitter.sv @@
// ---------------------------------------------------------------------------
// paged_frame_allocator_and_splitter: frame bitmap allocator, access splitter
// Resizes process slots over a free-frame bitmap and splits physical
// accesses into per-frame chunks through a page table held in RAM.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   command | start / busy          | cmd, process_slot, new_size,
//           |                       | phys_addr, byte_count
//   result  | result_valid (1 cyc)  | status, chunk_addr, chunk_len, last
//   config  | APB psel/penable      | paddr, pwdata, prdata (page_size)
//
// Every valid item first runs the bit-serial divider. A grow scans the bitmap
// one frame per cycle (up to NUM_FRAMES); a rollback or shrink reads each
// page's frame through the one page-table RAM port, then frees it; the lookup
// reads and compares each page searched, and each further chunk is a read, then
// an output. A bad slot or command is answered from idle. Reset clears bitmap,
// counts and sizes at once; no clearing pass. Results cannot be stalled.
// ---------------------------------------------------------------------------
module paged_frame_allocator_and_splitter #(
    parameter int NUM_FRAMES = pfa_pkg::DEF_NUM_FRAMES,
    parameter int NUM_PROCS  = pfa_pkg::DEF_NUM_PROCS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pfa_pkg::CMD_W-1:0]     cmd,
    input  logic [pfa_pkg::SLOT_W-1:0]    process_slot,
    input  logic [pfa_pkg::SIZE_W-1:0]    new_size,
    input  logic [pfa_pkg::ADDR_W-1:0]    phys_addr,
    input  logic [pfa_pkg::SIZE_W-1:0]    byte_count,
    output logic                          result_valid,
    output logic [pfa_pkg::STATUS_W-1:0]  status,
    output logic [pfa_pkg::ADDR_W-1:0]    chunk_addr,
    output logic [pfa_pkg::PS_W-1:0]      chunk_len,
    output logic                          last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pfa_pkg::*;

    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int SW  = (NUM_PROCS > 16) ? SLOT_W :
                         ((NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1);
    localparam int AW  = SW + FW;
    localparam int PT_DEPTH = (1 << SW) << FW;
    localparam logic [8:0]        NP_LIM = 9'(NUM_PROCS);
    localparam logic [CW-1:0]     NF_C   = CW'(NUM_FRAMES);
    localparam logic [SIZE_W-1:0] NF_S   = SIZE_W'(NUM_FRAMES);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DIV      = 11'b00000000010,
        S_GROW     = 11'b00000000100,
        S_ROLL_RD  = 11'b00000001000,
        S_ROLL_FR  = 11'b00000010000,
        S_SHR_RD   = 11'b00000100000,
        S_SHR_FR   = 11'b00001000000,
        S_SRCH_RD  = 11'b00010000000,
        S_SRCH_CMP = 11'b00100000000,
        S_NEXT_RD  = 11'b01000000000,
        S_NEXT_OUT = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [PS_W-1:0]     page_size_reg;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [SIZE_W-1:0]   nsize_reg, nsize_next;
    logic [SIZE_W-1:0]   bytes_reg, bytes_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SIZE_W-1:0]   want_reg, want_next;
    logic [SIZE_W-1:0]   frame_reg, frame_next;
    logic [PS_W-1:0]     off_reg, off_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       have_reg, have_next;
    logic [CW-1:0]       got_reg, got_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       page_reg, page_next;
    logic [NRES_W-1:0]   nres_reg, nres_next;
    logic [NUM_FRAMES-1:0] fbusy_reg, fbusy_next;
    logic [CW-1:0]       pcount_reg [NUM_PROCS];
    logic [SIZE_W-1:0]   psize_reg  [NUM_PROCS];
    logic                pc_we;
    logic [CW-1:0]       pc_wdata;
    logic [SIZE_W-1:0]   ps_wdata;

    logic                rv_reg, rv_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [ADDR_W-1:0]   ca_reg, ca_next;
    logic [PS_W-1:0]     cl_reg, cl_next;
    logic                last_reg, last_next;

    logic                div_start, div_done;
    logic [SIZE_W-1:0]   div_dividend, div_q;
    logic [PS_W-1:0]     div_r;

    logic                pt_we;
    logic [AW-1:0]       pt_waddr, pt_raddr;
    logic [FW-1:0]       pt_wdata, pt_rdata;

    logic                accept, slot_ok;
    logic [SW-1:0]       in_slot;
    logic [PS_W-1:0]     pw_val;
    logic [PS_W-1:0]     room_pg;
    logic [SIZE_W-1:0]   len_w;
    logic [FW+PS_W-1:0]  prod;

    assign accept  = start && !busy;
    assign in_slot = process_slot[SW-1:0];
    assign slot_ok = {5'b0, process_slot} < NP_LIM;
    assign busy    = state_reg != S_IDLE;

    // configuration port
    assign pready = 1'b1;
    assign prdata = {19'b0, page_size_reg};
    always_comb
    begin
        pw_val = pwdata[PS_W-1:0];
        if (pw_val == '0)
        begin
            pw_val = PS_W'(1);
        end
        else if (pw_val > PAGE_SIZE_MAX)
        begin
            pw_val = PAGE_SIZE_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg <= PAGE_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == 3'd0)
        begin
            page_size_reg <= pw_val;
        end
    end

    // divider and page table
    pfa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (page_size_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    pfa_ram #(
        .WIDTH (FW),
        .DEPTH (PT_DEPTH)
    ) u_pt (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    assign room_pg = page_size_reg - off_reg;
    assign prod    = pt_rdata * page_size_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        slot_next  = slot_reg;
        nsize_next = nsize_reg;
        bytes_next = bytes_reg;
        size_next  = size_reg;
        want_next  = want_reg;
        frame_next = frame_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        have_next  = have_reg;
        got_next   = got_reg;
        idx_next   = idx_reg;
        page_next  = page_reg;
        nres_next  = nres_reg;
        fbusy_next = fbusy_reg;
        pc_we      = 1'b0;
        pc_wdata   = cnt_reg;
        ps_wdata   = nsize_reg;
        rv_next    = 1'b0;
        st_next    = st_reg;
        ca_next    = ca_reg;
        cl_next    = cl_reg;
        last_next  = last_reg;
        div_start  = 1'b0;
        div_dividend = SIZE_W'(phys_addr);
        pt_we      = 1'b0;
        pt_waddr   = {slot_reg, have_reg[FW-1:0] + got_reg[FW-1:0]};
        pt_wdata   = idx_reg[FW-1:0];
        pt_raddr   = {slot_reg, idx_reg[FW-1:0]};
        len_w      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    slot_next  = in_slot;
                    nsize_next = new_size;
                    bytes_next = byte_count;
                    if (!slot_ok || cmd == CMD_BAD)
                    begin
                        rv_next = 1'b1; st_next = ST_ERR;
                        ca_next = '0; cl_next = '0; last_next = 1'b1;
                    end
                    else
                    begin
                        size_next = psize_reg[in_slot];
                        cnt_next  = pcount_reg[in_slot];
                        div_start = 1'b1;
                        div_dividend = (cmd == CMD_RESIZE) ?
                            SIZE_W'(new_size + SIZE_W'(page_size_reg) - 1'b1) :
                            SIZE_W'(phys_addr);
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rv_next = 1'b1; st_next = ST_OK;
                    ca_next = '0; cl_next = '0; last_next = 1'b1;
                    state_next = S_IDLE;
                    if (cmd_reg == CMD_RESIZE)
                    begin
                        want_next = div_q;
                        if (nsize_reg > size_reg)
                        begin
                            if (div_q > SIZE_W'(cnt_reg))
                            begin
                                if (div_q > NF_S)
                                begin
                                    st_next = ST_SHORT;
                                end
                                else
                                begin
                                    rv_next = 1'b0;
                                    have_next = cnt_reg;
                                    got_next = '0;
                                    idx_next = '0;
                                    state_next = S_GROW;
                                end
                            end
                            else
                            begin
                                pc_we = 1'b1;
                            end
                        end
                        else if (nsize_reg < size_reg)
                        begin
                            rv_next = 1'b0;
                            state_next = S_SHR_RD;
                        end
                    end
                    else
                    begin
                        frame_next = div_q;
                        off_next   = div_r;
                        if (cmd_reg == CMD_WRITE &&
                            ({1'b0, bytes_reg} + {{(SIZE_W+1-PS_W){1'b0}}, div_r})
                                > {1'b0, size_reg})
                        begin
                            st_next = ST_ERR;
                        end
                        else
                        begin
                            rv_next = 1'b0;
                            if (cmd_reg == CMD_READ)
                            begin
                                bytes_next = (size_reg > SIZE_W'(div_r)) ?
                                    ((bytes_reg > size_reg - SIZE_W'(div_r)) ?
                                        size_reg - SIZE_W'(div_r) : bytes_reg) : '0;
                            end
                            idx_next = '0;
                            state_next = S_SRCH_RD;
                        end
                    end
                end
            end
            S_GROW:
            begin
                if (SIZE_W'(have_reg) + SIZE_W'(got_reg) == want_reg)
                begin
                    pc_we = 1'b1;
                    pc_wdata = CW'(want_reg);
                    rv_next = 1'b1; st_next = ST_OK;
                    ca_next = '0; cl_next = '0; last_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (idx_reg == NF_C)
                begin
                    idx_next = '0;
                    state_next = S_ROLL_RD;
                end
                else
                begin
                    if (!fbusy_reg[idx_reg[FW-1:0]])
                    begin
                        fbusy_next[idx_reg[FW-1:0]] = 1'b1;
                        pt_we = 1'b1;
                        got_next = got_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ROLL_RD:
            begin
                if (idx_reg == got_reg)
                begin
                    rv_next = 1'b1; st_next = ST_SHORT;
                    ca_next = '0; cl_next = '0; last_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    pt_raddr = {slot_reg, have_reg[FW-1:0] + idx_reg[FW-1:0]};
                    idx_next = idx_reg + 1'b1;
                    state_next = S_ROLL_FR;
                end
            end
            S_ROLL_FR:
            begin
                if (CW'(pt_rdata) < NF_C)
                begin
                    fbusy_next[pt_rdata] = 1'b0;
                end
                state_next = S_ROLL_RD;
            end
            S_SHR_RD:
            begin
                if (SIZE_W'(cnt_reg) > want_reg)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    pt_raddr = {slot_reg, FW'(cnt_reg - 1'b1)};
                    state_next = S_SHR_FR;
                end
                else
                begin
                    pc_we = 1'b1;
                    rv_next = 1'b1; st_next = ST_OK;
                    ca_next = '0; cl_next = '0; last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHR_FR:
            begin
                if (CW'(pt_rdata) < NF_C)
                begin
                    fbusy_next[pt_rdata] = 1'b0;
                end
                state_next = S_SHR_RD;
            end
            S_SRCH_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    rv_next = 1'b1; st_next = ST_ERR;
                    ca_next = '0; cl_next = '0; last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SRCH_CMP:
            begin
                if (SIZE_W'(pt_rdata) == frame_reg)
                begin
                    len_w = (bytes_reg > SIZE_W'(room_pg)) ? SIZE_W'(room_pg) : bytes_reg;
                    bytes_next = bytes_reg - len_w;
                    page_next = idx_reg;
                    nres_next = NRES_W'(1);
                    rv_next = 1'b1; st_next = ST_OK;
                    ca_next = ADDR_W'(frame_reg * SIZE_W'(page_size_reg)) + ADDR_W'(off_reg);
                    cl_next = PS_W'(len_w);
                    last_next = (bytes_reg == len_w);
                    state_next = (bytes_reg == len_w) ? S_IDLE : S_NEXT_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_NEXT_RD:
            begin
                if ((page_reg + 1'b1) >= cnt_reg || nres_reg >= MAX_RESULTS - 1'b1)
                begin
                    rv_next = 1'b1; st_next = ST_ERR;
                    ca_next = '0; cl_next = '0; last_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    page_next = page_reg + 1'b1;
                    pt_raddr = {slot_reg, FW'(page_reg + 1'b1)};
                    state_next = S_NEXT_OUT;
                end
            end
            S_NEXT_OUT:
            begin
                len_w = (bytes_reg > SIZE_W'(page_size_reg)) ?
                    SIZE_W'(page_size_reg) : bytes_reg;
                bytes_next = bytes_reg - len_w;
                nres_next = nres_reg + 1'b1;
                rv_next = 1'b1; st_next = ST_OK;
                ca_next = ADDR_W'(prod);
                cl_next = PS_W'(len_w);
                last_next = (bytes_reg == len_w);
                state_next = (bytes_reg == len_w) ? S_IDLE : S_NEXT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            fbusy_reg <= '0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                pcount_reg[i] <= '0;
                psize_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            fbusy_reg <= fbusy_next;
            if (pc_we)
            begin
                pcount_reg[slot_reg] <= pc_wdata;
                psize_reg[slot_reg]  <= ps_wdata;
            end
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        slot_reg  <= slot_next;
        nsize_reg <= nsize_next;
        bytes_reg <= bytes_next;
        size_reg  <= size_next;
        want_reg  <= want_next;
        frame_reg <= frame_next;
        off_reg   <= off_next;
        cnt_reg   <= cnt_next;
        have_reg  <= have_next;
        got_reg   <= got_next;
        idx_reg   <= idx_next;
        page_reg  <= page_next;
        nres_reg  <= nres_next;
        st_reg    <= st_next;
        ca_reg    <= ca_next;
        cl_reg    <= cl_next;
        last_reg  <= last_next;
    end

    assign result_valid = rv_reg;
    assign status       = st_reg;
    assign chunk_addr   = ca_reg;
    assign chunk_len    = cl_reg;
    assign last         = last_reg;

endmodule

@@ rtl/pfa_ram.sv @@
// ---------------------------------------------------------------------------
// pfa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pfa_div.sv @@
// ---------------------------------------------------------------------------
// pfa_div: restoring divider, one quotient bit per cycle
// Divides a 19-bit value by the 13-bit page size; done pulses when finished.
// ---------------------------------------------------------------------------
module pfa_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pfa_pkg::SIZE_W-1:0] dividend,
    input  logic [pfa_pkg::PS_W-1:0]   divisor,
    output logic                      done,
    output logic [pfa_pkg::SIZE_W-1:0] quotient,
    output logic [pfa_pkg::PS_W-1:0]   remainder
);
    import pfa_pkg::*;

    localparam int CNT_W = $clog2(SIZE_W + 1);

    logic [SIZE_W-1:0] quo_reg;
    logic [PS_W-1:0]   rem_reg;
    logic [PS_W-1:0]   dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [PS_W:0]     trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[SIZE_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(SIZE_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift in one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[SIZE_W-2:0], fits};
            rem_reg <= fits ? PS_W'(trial - {1'b0, dvs_reg}) : trial[PS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/pfa_chk.sv @@
// ---------------------------------------------------------------------------
// pfa_chk: port-level checks for the paged frame allocator
// Watches the command and result ports; bound to the top level.
// ---------------------------------------------------------------------------
module pfa_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          result_valid,
    input logic [pfa_pkg::STATUS_W-1:0]  status,
    input logic [pfa_pkg::PS_W-1:0]      chunk_len,
    input logic                          last
);
    import pfa_pkg::*;

    // an error or shortage always ends the item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |-> last)
        else $error("error word without last");

    // more words follow a non-final word
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> busy || result_valid)
        else $error("block idle before final word");

    // an accepted command keeps the block busy or answers at once
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || (result_valid && last))
        else $error("accepted command dropped");

    // a chunk never exceeds the largest page size
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> chunk_len <= PAGE_SIZE_MAX)
        else $error("chunk longer than a page");

endmodule

bind paged_frame_allocator_and_splitter pfa_chk u_pfa_chk (.*);

@@ verif/tb_paged_frame_allocator_and_splitter.sv @@
// ---------------------------------------------------------------------------
// tb_paged_frame_allocator_and_splitter: self-checking bench for the allocator
// Drives a directed table, page-per-byte cap cases, then random resize, read,
// write and bad traffic in bursts under several page sizes, predicts every
// result word in the bench, compares each field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_paged_frame_allocator_and_splitter;
    import pfa_pkg::*;

    localparam int NFRM       = DEF_NUM_FRAMES;
    localparam int NPROC      = DEF_NUM_PROCS;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        status_t           st;
        logic [ADDR_W-1:0] addr;
        logic [PS_W-1:0]   len;
        logic              fin;
    } chunk_t;

    typedef struct {
        cmd_t    c;
        int      slot;
        int      nsize;
        int      pa;
        int      bc;
        bit      typed;
        status_t tst;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [CMD_W-1:0]    cmd = '0;
    logic [SLOT_W-1:0]   process_slot = '0;
    logic [SIZE_W-1:0]   new_size = '0;
    logic [ADDR_W-1:0]   phys_addr = '0;
    logic [SIZE_W-1:0]   byte_count = '0;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   chunk_addr;
    logic [PS_W-1:0]     chunk_len;
    logic                last;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // mirror of the allocator state
    int unsigned    cur_page;
    bit             frame_taken [NFRM];
    logic [5:0]     frame_of [NPROC][NFRM];
    int unsigned    pages_held [NPROC];
    int unsigned    bytes_held [NPROC];

    chunk_t chunks_due [$];
    int     fails;
    int     cycles;
    int     items_sent;
    int     chunks_seen;
    int     short_seen;
    int     err_seen;
    row_t   dir_rows [$];

    paged_frame_allocator_and_splitter i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .process_slot(process_slot), .new_size(new_size),
        .phys_addr(phys_addr), .byte_count(byte_count),
        .result_valid(result_valid), .status(status), .chunk_addr(chunk_addr),
        .chunk_len(chunk_len), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        begin
            fails++;
            $display("MISMATCH @%0d: %s", cycles, what);
        end
    endtask

    function automatic void due(status_t st, int unsigned a, int unsigned l, bit f);
        chunk_t r;
        r.st   = st;
        r.addr = a[ADDR_W-1:0];
        r.len  = l[PS_W-1:0];
        r.fin  = f;
        chunks_due.push_back(r);
    endfunction

    function automatic status_t resize_slot(int s, int unsigned ns);
        int unsigned want, have, need, got;
        int unsigned grabbed [NFRM];
        begin
            want = (ns + cur_page - 1) / cur_page;
            have = pages_held[s];
            got  = 0;
            if (ns > bytes_held[s])
            begin
                if (want > have)
                begin
                    need = want - have;
                    if (want > NFRM)
                        return ST_SHORT;
                    for (int i = 0; i < NFRM && got < need; i++)
                        if (!frame_taken[i])
                        begin
                            frame_taken[i] = 1'b1;
                            grabbed[got++] = i;
                        end
                    if (got != need)
                    begin
                        // roll back a partial claim
                        for (int i = 0; i < got; i++)
                            frame_taken[grabbed[i]] = 1'b0;
                        return ST_SHORT;
                    end
                    for (int i = 0; i < need; i++)
                        frame_of[s][have + i] = grabbed[i][5:0];
                    pages_held[s] = want;
                end
                bytes_held[s] = ns;
            end
            else if (ns < bytes_held[s])
            begin
                while (pages_held[s] > want)
                begin
                    pages_held[s]--;
                    frame_taken[frame_of[s][pages_held[s]]] = 1'b0;
                end
                bytes_held[s] = ns;
            end
            return ST_OK;
        end
    endfunction

    function automatic void split_access(int s, bit wr, int unsigned a, int unsigned bc);
        int unsigned frm, off, sz, cnt, b, len, pg, n;
        bit hit;
        begin
            frm = a / cur_page;
            off = a % cur_page;
            sz  = bytes_held[s];
            cnt = pages_held[s];
            b   = bc;
            hit = 1'b0;
            pg  = 0;
            if (wr)
            begin
                if (b + off > sz)
                begin
                    due(ST_ERR, 0, 0, 1'b1);
                    return;
                end
            end
            else if (b > ((sz > off) ? sz - off : 0))
                b = (sz > off) ? sz - off : 0;
            for (int i = 0; i < cnt && i < NFRM; i++)
                if (!hit && frame_of[s][i] == frm)
                begin
                    pg  = i;
                    hit = 1'b1;
                end
            if (!hit)
            begin
                due(ST_ERR, 0, 0, 1'b1);
                return;
            end
            len = (b > cur_page - off) ? cur_page - off : b;
            b  -= len;
            due(ST_OK, a, len, b == 0);
            n = 1;
            while (b > 0)
            begin
                // stop on a walk past the table or the result cap
                if (pg + 1 >= cnt || n >= MAX_RESULTS - 1)
                begin
                    due(ST_ERR, 0, 0, 1'b1);
                    return;
                end
                pg++;
                len = (b > cur_page) ? cur_page : b;
                b  -= len;
                due(ST_OK, frame_of[s][pg] * cur_page, len, b == 0);
                n++;
            end
        end
    endfunction

    function automatic void predict_item(cmd_t c, int s, int unsigned ns,
                                         int unsigned a, int unsigned bc);
        if (c == CMD_BAD || s >= NPROC)
            due(ST_ERR, 0, 0, 1'b1);
        else if (c == CMD_RESIZE)
            due(resize_slot(s, ns), 0, 0, 1'b1);
        else
            split_access(s, c == CMD_WRITE, a, bc);
    endfunction

    // hand one command word over and predict what it yields
    task automatic send_item(cmd_t c, int s, int unsigned ns, int unsigned a,
                             int unsigned bc, bit typed = 1'b0, status_t tst = ST_OK);
        int n_before;
        begin
            cmd          <= c;
            process_slot <= s[SLOT_W-1:0];
            new_size     <= ns[SIZE_W-1:0];
            phys_addr    <= a[ADDR_W-1:0];
            byte_count   <= bc[SIZE_W-1:0];
            start        <= 1'b1;
            do @(posedge clk); while (busy);
            items_sent++;
            n_before = chunks_due.size();
            predict_item(c, s, ns[SIZE_W-1:0], a[ADDR_W-1:0], bc[SIZE_W-1:0]);
            if (typed)
            begin
                while (chunks_due.size() > n_before)
                    void'(chunks_due.pop_back());
                due(tst, 0, 0, 1'b1);
            end
        end
    endtask

    // random gap between bursts; drop start only when a gap follows
    task automatic sender_gap();
        int g;
        begin
            g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (g > 0)
            begin
                start <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        begin
            start <= 1'b0;
            while (chunks_due.size() != 0)
                @(posedge clk);
            repeat (DRAIN_WAIT) @(posedge clk);
        end
    endtask

    task automatic set_page_size(int unsigned v);
        int unsigned m;
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= '0;
            pwdata  <= v;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            m = v & 32'h1FFF;
            cur_page = (m == 0) ? 1 : (m > PAGE_SIZE_MAX) ? PAGE_SIZE_MAX : m;
            @(posedge clk);
        end
    endtask

    task automatic free_all();
        for (int s = 0; s < NPROC; s++)
        begin
            send_item(CMD_RESIZE, s, 0, 0, 0);
            sender_gap();
        end
    endtask

    // mostly well-formed traffic on mapped pages, some noise
    task automatic random_item();
        int r, s, pg;
        int unsigned top, a, bc;
        cmd_t c;
        begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, NPROC - 1);
            top = NFRM * cur_page;
            if (top > 262144)
                top = 262144;
            if (r < 12)
            begin
                c = cmd_t'($urandom_range(0, 3));
                send_item(c, s, $urandom_range(0, 262144), $urandom_range(0, 262143),
                          $urandom_range(0, 262144));
            end
            else if (r < 40 || pages_held[s] == 0)
                send_item(CMD_RESIZE, s, ($urandom_range(0, 2) == 0) ?
                          $urandom_range(0, top) : $urandom_range(0, top / 8), 0, 0);
            else
            begin
                pg = $urandom_range(0, pages_held[s] - 1);
                a  = frame_of[s][pg] * cur_page + $urandom_range(0, cur_page - 1);
                bc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 262144)
                                                 : $urandom_range(0, bytes_held[s] + 2);
                c  = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
                send_item(c, s, $urandom_range(0, 262144), a, bc);
            end
            sender_gap();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        chunk_t e;
        if (rst_n && result_valid)
        begin
            chunks_seen++;
            if (chunks_due.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                e = chunks_due.pop_front();
                if (status == ST_SHORT)
                    short_seen++;
                if (status == ST_ERR)
                    err_seen++;
                if (status !== e.st)
                    report_mismatch($sformatf("status %0d exp %0d", status, e.st));
                if (chunk_addr !== e.addr)
                    report_mismatch($sformatf("chunk_addr %0d exp %0d", chunk_addr, e.addr));
                if (chunk_len !== e.len)
                    report_mismatch($sformatf("chunk_len %0d exp %0d", chunk_len, e.len));
                if (last !== e.fin)
                    report_mismatch($sformatf("last %0b exp %0b", last, e.fin));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_paged_frame_allocator_and_splitter NOT OK");
            $finish;
        end
    end

    initial
    begin
        int unsigned sizes [7];
        int n;
        cur_page = PAGE_SIZE_RESET;
        foreach (frame_taken[i])
            frame_taken[i] = 1'b0;
        foreach (pages_held[i])
        begin
            pages_held[i] = 0;
            bytes_held[i] = 0;
        end

        // directed table at the reset page size of 64
        dir_rows = '{
            '{CMD_RESIZE, 0, 0,      0,      0,      1, ST_OK},
            '{CMD_RESIZE, 0, 262144, 0,      0,      1, ST_SHORT},
            '{CMD_BAD,    5, 0,      0,      0,      1, ST_ERR},
            '{CMD_READ,   1, 0,      0,      10,     1, ST_ERR},
            '{CMD_WRITE,  1, 0,      0,      1,      1, ST_ERR},
            '{CMD_RESIZE, 0, 200,    0,      0,      0, ST_OK},
            '{CMD_READ,   0, 0,      0,      0,      0, ST_OK},
            '{CMD_READ,   0, 0,      10,     500,    0, ST_OK},
            '{CMD_WRITE,  0, 0,      70,     130,    0, ST_OK},
            '{CMD_WRITE,  0, 0,      0,      201,    0, ST_OK},
            '{CMD_RESIZE, 1, 4096,   0,      0,      0, ST_OK},
            '{CMD_RESIZE, 1, 3840,   0,      0,      0, ST_OK},
            '{CMD_RESIZE, 2, 1,      0,      0,      0, ST_OK},
            '{CMD_RESIZE, 1, 100,    0,      0,      0, ST_OK},
            '{CMD_READ,   1, 0,      262143, 262144, 0, ST_OK},
            '{CMD_RESIZE, 0, 300,    0,      0,      0, ST_OK},
            '{CMD_READ,   0, 0,      0,      262144, 0, ST_OK},
            '{CMD_WRITE,  15, 0,     0,      0,      1, ST_ERR}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_page_size(PAGE_SIZE_RESET);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].c, dir_rows[i].slot, dir_rows[i].nsize,
                      dir_rows[i].pa, dir_rows[i].bc, dir_rows[i].typed, dir_rows[i].tst);
            sender_gap();
        end
        drain();

        // one page per byte: hit the result cap, then a walk past the table
        set_page_size(1);
        free_all();
        send_item(CMD_RESIZE, 3, 64, 0, 0);
        send_item(CMD_READ, 3, 0, frame_of[3][0], 64);
        drain();
        set_page_size(2);
        free_all();
        send_item(CMD_RESIZE, 3, 64, 0, 0);
        drain();
        set_page_size(1);
        send_item(CMD_READ, 3, 0, frame_of[3][0], 100);
        drain();

        // random phases over page sizes, extremes and out-of-range values
        sizes = '{16, 1, 4096, 0, 8191, $urandom_range(2, 300), 64};
        foreach (sizes[p])
        begin
            set_page_size(sizes[p]);
            n = 0;
            while (n < 25)
            begin
                random_item();
                n++;
                if (n == 15 && p == 2)
                    drain();
            end
            drain();
        end

        $display("ran %0d commands, checked %0d result words over %0d page sizes",
                 items_sent, chunks_seen, $size(sizes) + 4);
        $display("seen %0d shortage and %0d error results", short_seen, err_seen);
        if (fails == 0 && chunks_due.size() == 0)
            $display("tb_paged_frame_allocator_and_splitter OK");
        else
            $display("tb_paged_frame_allocator_and_splitter NOT OK");
        $finish;
    end

endmodule
